### hdl/pop_interval_rate_meter_core_defines.svh
// Assertion macros for the pop interval rate meter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef POP_INTERVAL_RATE_METER_CORE_DEFINES_SVH
`define POP_INTERVAL_RATE_METER_CORE_DEFINES_SVH

// same-cycle implication
`define PRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/prm_pkg.sv
// Shared constants and types for the pop interval rate meter.
// No dependencies; used by the interfaces, the divider and the top level.
package prm_pkg;

	localparam int GAP_DEPTH     = 64;
	localparam int TIME_BITS     = 32;
	localparam int SUM_W         = 40;
	localparam int WIN_W         = 16;
	localparam int AVG_W         = 32;
	localparam int EPS_W         = 10;
	localparam int IDX_W         = $clog2(GAP_DEPTH);
	localparam int CNT_W         = IDX_W + 1;
	localparam int STEP_W        = $clog2(SUM_W + 1);
	localparam int MS_PER_SECOND = 1000;
	localparam int WINDOW_RESET  = 1000;

	// 1000 aligned to the top so that EPS_W steps consume it
	localparam logic [SUM_W-1:0] EPS_DIVIDEND = SUM_W'(MS_PER_SECOND) << (SUM_W - EPS_W);

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_st_t;

endpackage

### hdl/prm_ifs.sv
// Channel interfaces for the pop interval rate meter: events, results, config.
// Depends on prm_pkg for field widths.
interface prm_event_if;
	logic                           valid;
	logic                           ready;
	logic [prm_pkg::TIME_BITS-1:0]  event_time_ms;

	modport source (output valid, output event_time_ms, input ready);
	modport sink (input valid, input event_time_ms, output ready);
endinterface

interface prm_result_if;
	logic                       valid;
	logic                       ready;
	logic [prm_pkg::AVG_W-1:0]  average_gap_ms;
	logic [prm_pkg::EPS_W-1:0]  events_per_second;
	logic [prm_pkg::CNT_W-1:0]  gap_count;

	modport source (output valid, output average_gap_ms, output events_per_second,
		output gap_count, input ready);
	modport sink (input valid, input average_gap_ms, input events_per_second,
		input gap_count, output ready);
endinterface

interface prm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [prm_pkg::WIN_W-1:0]  window_ms;

	modport source (output valid, output window_ms, input ready);
	modport sink (input valid, input window_ms, output ready);
endinterface

### hdl/prm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/prm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on prm_pkg; the dividend is consumed MSB first over ctl.steps steps.
module prm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prm_pkg::div_ctl_t               ctl,
	input  logic [prm_pkg::SUM_W-1:0]       dividend,
	input  logic [prm_pkg::TIME_BITS-1:0]   divisor,
	output prm_pkg::div_st_t                st,
	output logic [prm_pkg::SUM_W-1:0]       quotient
);

	logic [prm_pkg::TIME_BITS-1:0]  rem_q;
	logic [prm_pkg::TIME_BITS-1:0]  dsr_q;
	logic [prm_pkg::SUM_W-1:0]      dvd_q;
	logic [prm_pkg::STEP_W-1:0]     cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [prm_pkg::TIME_BITS:0]    rem_shift;
	logic                           ge;
	logic [prm_pkg::TIME_BITS:0]    rem_diff;

	assign rem_shift = {rem_q, dvd_q[prm_pkg::SUM_W-1]};
	assign ge        = rem_shift >= {1'b0, dsr_q};
	assign rem_diff  = rem_shift - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == prm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_diff[prm_pkg::TIME_BITS-1:0] : rem_shift[prm_pkg::TIME_BITS-1:0];
			dvd_q <= {dvd_q[prm_pkg::SUM_W-2:0], ge};
		end
	end

	assign st.busy  = busy_q;
	assign st.done  = done_q;
	assign quotient = dvd_q;

endmodule

### hdl/pop_interval_rate_meter_core.sv
// Top level of the pop interval rate meter: sequencer, gap store, shared divider.
// Depends on prm_pkg, prm_ifs, prm_ram, prm_div and the defines header.
//
// Each event transfer carries a millisecond timestamp; the block keeps up to 64
// gaps between events in a ring store, evicting the oldest one when the sum
// would pass window_ms and again when the store is full, and answers every event
// with one result: average gap (sum / count), events per second (1000 / average)
// and the gap count. The first event after reset only records its time and stores
// no gap; it passes through ST_AVG and ST_DONE before events is ready again. Every
// later event passes from its accept through ST_CHECK, ST_FULL and ST_STORE, with
// ST_EVICT for each eviction; ST_AVG then starts one bit-serial divider, used twice,
// for the average and then the rate (skipped when the average is 0), and ST_DONE
// loads the output register. events is not ready until the result is loaded into
// the output register, so a result held by results.ready stalls the next event.
// window_ms may be written at any time while idle.
`include "pop_interval_rate_meter_core_defines.svh"

module pop_interval_rate_meter_core (
	input  logic          clk,
	input  logic          arst_n,
	prm_cfg_if.sink       cfg,
	prm_event_if.sink     events,
	prm_result_if.source  results
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EVICT,
		ST_FULL,
		ST_STORE,
		ST_AVG,
		ST_AVG_WAIT,
		ST_EPS_WAIT,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [prm_pkg::WIN_W-1:0]      window_q;
	logic                           first_q;
	logic [prm_pkg::TIME_BITS-1:0]  prev_q;
	logic [prm_pkg::TIME_BITS-1:0]  gap_q;
	logic [prm_pkg::IDX_W-1:0]      oldest_q;
	logic [prm_pkg::CNT_W-1:0]      count_q;
	logic [prm_pkg::SUM_W-1:0]      sum_q;
	logic [prm_pkg::AVG_W-1:0]      avg_q;
	logic [prm_pkg::EPS_W-1:0]      eps_q;
	logic                           res_valid_q;
	logic [prm_pkg::AVG_W-1:0]      res_avg_q;
	logic [prm_pkg::EPS_W-1:0]      res_eps_q;
	logic [prm_pkg::CNT_W-1:0]      res_cnt_q;

	logic [prm_pkg::SUM_W:0]        sum_gap;
	logic                           over;
	logic                           full;
	logic                           empty;
	logic [prm_pkg::CNT_W-1:0]      count_dec;
	logic [prm_pkg::IDX_W:0]        wr_pos;
	logic [prm_pkg::IDX_W-1:0]      wr_addr;
	logic                           ram_we;
	logic                           ram_re;
	logic [prm_pkg::TIME_BITS-1:0]  ram_rdata;
	logic                           out_free;

	prm_pkg::div_ctl_t              div_ctl;
	prm_pkg::div_st_t               div_st;
	logic [prm_pkg::SUM_W-1:0]      div_dividend;
	logic [prm_pkg::TIME_BITS-1:0]  div_divisor;
	logic [prm_pkg::SUM_W-1:0]      div_quot;
	logic [prm_pkg::AVG_W-1:0]      quot_avg;

	assign sum_gap = {1'b0, sum_q}
		+ {{(prm_pkg::SUM_W + 1 - prm_pkg::TIME_BITS){1'b0}}, gap_q};
	assign over    = sum_gap > {{(prm_pkg::SUM_W + 1 - prm_pkg::WIN_W){1'b0}}, window_q};
	assign full    = count_q == prm_pkg::CNT_W'(prm_pkg::GAP_DEPTH);
	assign empty   = count_q == '0;
	assign count_dec = count_q - 1'b1;
	assign wr_pos  = {1'b0, oldest_q} + {1'b0, count_q[prm_pkg::IDX_W-1:0]};
	assign wr_addr = (wr_pos >= (prm_pkg::IDX_W+1)'(prm_pkg::GAP_DEPTH))
		? prm_pkg::IDX_W'(wr_pos - (prm_pkg::IDX_W+1)'(prm_pkg::GAP_DEPTH))
		: wr_pos[prm_pkg::IDX_W-1:0];

	assign ram_we   = state_q == ST_STORE;
	assign ram_re   = ((state_q == ST_CHECK) && over && !empty) || ((state_q == ST_FULL) && full);
	assign quot_avg = div_quot[prm_pkg::AVG_W-1:0];
	assign out_free = !res_valid_q || results.ready;

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.steps = prm_pkg::STEP_W'(prm_pkg::SUM_W);
		div_dividend  = sum_q;
		div_divisor   = {{(prm_pkg::TIME_BITS - prm_pkg::CNT_W){1'b0}}, count_q};
		unique case (state_q)
			ST_AVG: begin
				div_ctl.start = !empty;
			end
			ST_AVG_WAIT: begin
				div_ctl.start = div_st.done && (quot_avg != '0);
				div_ctl.steps = prm_pkg::STEP_W'(prm_pkg::EPS_W);
				div_dividend  = prm_pkg::EPS_DIVIDEND;
				div_divisor   = quot_avg;
			end
			default: begin
			end
		endcase
	end

	prm_ram #(
		.WIDTH(prm_pkg::TIME_BITS),
		.DEPTH(prm_pkg::GAP_DEPTH)
	) u_gap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (gap_q),
		.re    (ram_re),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	prm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.st       (div_st),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= prm_pkg::WIN_W'(prm_pkg::WINDOW_RESET);
			first_q     <= 1'b1;
			prev_q      <= '0;
			gap_q       <= '0;
			oldest_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			eps_q       <= '0;
			res_valid_q <= 1'b0;
			res_avg_q   <= '0;
			res_eps_q   <= '0;
			res_cnt_q   <= '0;
		end else begin
			if (cfg.valid) begin
				window_q <= cfg.window_ms;
			end
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (events.valid) begin
						prev_q <= events.event_time_ms;
						gap_q  <= events.event_time_ms - prev_q;
						if (first_q) begin
							first_q <= 1'b0;
							state_q <= ST_AVG;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					state_q <= (over && !empty) ? ST_EVICT : ST_FULL;
				end
				ST_EVICT: begin
					sum_q    <= sum_q - {{(prm_pkg::SUM_W - prm_pkg::TIME_BITS){1'b0}}, ram_rdata};
					oldest_q <= (oldest_q == prm_pkg::IDX_W'(prm_pkg::GAP_DEPTH - 1))
						? '0 : oldest_q + 1'b1;
					count_q  <= count_dec;
					state_q  <= ST_FULL;
				end
				ST_FULL: begin
					state_q <= full ? ST_EVICT : ST_STORE;
				end
				ST_STORE: begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_gap[prm_pkg::SUM_W-1:0];
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					avg_q   <= '0;
					eps_q   <= '0;
					state_q <= empty ? ST_DONE : ST_AVG_WAIT;
				end
				ST_AVG_WAIT: begin
					if (div_st.done) begin
						avg_q   <= quot_avg;
						state_q <= (quot_avg != '0) ? ST_EPS_WAIT : ST_DONE;
					end
				end
				ST_EPS_WAIT: begin
					if (div_st.done) begin
						eps_q   <= div_quot[prm_pkg::EPS_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_avg_q <= avg_q;
						res_eps_q <= eps_q;
						res_cnt_q <= count_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg.ready                 = 1'b1;
	assign events.ready              = state_q == ST_IDLE;
	assign results.valid             = res_valid_q;
	assign results.average_gap_ms    = res_avg_q;
	assign results.events_per_second = res_eps_q;
	assign results.gap_count         = res_cnt_q;

	`PRM_ASSERT_IMP(a_count_range, count_q[prm_pkg::IDX_W], full, "count above depth")
	`PRM_ASSERT_NXT(a_evict, state_q == ST_EVICT, count_q == $past(count_dec), "evict count")
	`PRM_ASSERT_IMP(a_div_start_idle, div_ctl.start, !div_st.busy, "divider restarted")

endmodule
